### rtl/websocket_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// WebSocket frame decoder assertion macros
// Concurrent check wrappers used by the decoder parser.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DECODER_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// prop must hold at every rising clock edge outside reset
`define WSFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true outside reset
`define WSFD_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define WSFD_ASSERT(label, clk, rst_n, prop, msg)
`define WSFD_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

### rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder package
// Opcodes, length codes and the result word shared by the decoder modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_PING = 4'h9;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    // remaining-count preset for the extended length byte counter
    localparam logic [2:0] EXT_CNT_16 = 3'd1;
    localparam logic [2:0] EXT_CNT_64 = 3'd7;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_kind;
        logic       empty_frame;
        logic       last_in_frame;
    } res_t;

endpackage

### rtl/websocket_frame_decoder.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder
// Byte-serial frame parser: emits unmasked payload of final text frames and all
// ping frames, with an empty marker for zero-length frames of those kinds.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, rx_byte               | word in
//   out     | out_valid, out_stall, payload_byte,       | word out
//           | frame_kind, empty_frame, last_in_frame    |
//
// One byte per clock while out_stall is low; a byte is registered, then its result.
// The cycle is set by the 64-bit payload length decrement and zero check.
// Reset is asynchronous; the block takes bytes right after it, no clearing.
// out_stall reaches in_stall in the same cycle once both registers are full.
// ----------------------------------------------------------------------------
module websocket_frame_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic       frame_kind,
    output logic       empty_frame,
    output logic       last_in_frame
);
    import wsfd_pkg::*;

    logic       free;
    logic       step;
    logic [7:0] byte_q;
    logic       res_valid;
    res_t       res;
    res_t       out_res;

    wsfd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .free     (free),
        .step     (step),
        .byte_q   (byte_q)
    );

    wsfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_q    (byte_q),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign payload_byte  = out_res.payload_byte;
    assign frame_kind    = out_res.frame_kind;
    assign empty_frame   = out_res.empty_frame;
    assign last_in_frame = out_res.last_in_frame;

endmodule

### rtl/wsfd_in_stage.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder input stage
// Registers one received byte and holds it until the parser can step.
// ----------------------------------------------------------------------------
module wsfd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       free,
    output logic       step,
    output logic [7:0] byte_q
);
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    assign step     = valid_reg && free;
    assign in_stall = valid_reg && !free;
    assign accept   = in_valid && !in_stall;
    assign byte_q   = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

### rtl/wsfd_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder parser
// Header state machine, length counter and payload unmasking, one byte a step.
// ----------------------------------------------------------------------------
`include "websocket_frame_decoder_defines.svh"

module wsfd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     byte_q,
    output logic           res_valid,
    output wsfd_pkg::res_t res
);
    import wsfd_pkg::*;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]  phase_reg,  phase_next;
    logic        fin_reg,    fin_next;
    logic [3:0]  op_reg,     op_next;
    logic        masked_reg, masked_next;
    logic [2:0]  ext_cnt_reg, ext_cnt_next;
    logic [63:0] rem_reg,    rem_next;
    logic [31:0] key_reg,    key_next;
    logic [1:0]  kidx_reg,   kidx_next;

    logic        emits;
    logic        rem_is_one;

    assign emits      = ((op_reg == OP_TEXT) && fin_reg) || (op_reg == OP_PING);
    assign rem_is_one = (rem_reg == 64'd1);

    always_comb
    begin
        logic        len_done;
        logic        len_masked;
        logic [63:0] len_rem;
        logic        hdr_done;
        logic [63:0] hdr_rem;
        logic [63:0] shifted_rem;
        logic [7:0]  kb;

        phase_next   = phase_reg;
        fin_next     = fin_reg;
        op_next      = op_reg;
        masked_next  = masked_reg;
        ext_cnt_next = ext_cnt_reg;
        rem_next     = rem_reg;
        key_next     = key_reg;
        kidx_next    = kidx_reg;
        res_valid    = 1'b0;
        res          = '0;
        len_done     = 1'b0;
        len_masked   = masked_reg;
        len_rem      = rem_reg;
        hdr_done     = 1'b0;
        hdr_rem      = rem_reg;
        shifted_rem  = {rem_reg[55:0], byte_q};

        case (kidx_reg)
            2'd0:    kb = key_reg[31:24];
            2'd1:    kb = key_reg[23:16];
            2'd2:    kb = key_reg[15:8];
            default: kb = key_reg[7:0];
        endcase

        if (step)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next   = byte_q[7];
                    op_next    = byte_q[3:0];
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = byte_q[7];
                    key_next    = '0;
                    rem_next    = '0;
                    if (byte_q[6:0] == LEN_CODE_16)
                    begin
                        ext_cnt_next = EXT_CNT_16;
                        phase_next   = PH_EXTLEN;
                    end
                    else if (byte_q[6:0] == LEN_CODE_64)
                    begin
                        ext_cnt_next = EXT_CNT_64;
                        phase_next   = PH_EXTLEN;
                    end
                    else
                    begin
                        ext_cnt_next = '0;
                        rem_next     = {57'd0, byte_q[6:0]};
                        len_done     = 1'b1;
                        len_masked   = byte_q[7];
                        len_rem      = {57'd0, byte_q[6:0]};
                    end
                end
                PH_EXTLEN:
                begin
                    rem_next = shifted_rem;
                    if (ext_cnt_reg == '0)
                    begin
                        len_done = 1'b1;
                        len_rem  = shifted_rem;
                    end
                    else
                    begin
                        ext_cnt_next = ext_cnt_reg - 3'd1;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], byte_q};
                    if (kidx_reg == 2'd3)
                    begin
                        hdr_done = 1'b1;
                    end
                    else
                    begin
                        kidx_next = kidx_reg + 2'd1;
                    end
                end
                PH_PAYLOAD:
                begin
                    kidx_next = kidx_reg + 2'd1;
                    rem_next  = rem_reg - 64'd1;
                    if (rem_is_one)
                    begin
                        phase_next = PH_HDR0;
                    end
                    if (emits)
                    begin
                        res_valid         = 1'b1;
                        res.payload_byte  = byte_q ^ kb;
                        res.frame_kind    = (op_reg == OP_PING);
                        res.last_in_frame = rem_is_one;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            // length known: key bytes follow when masked
            if (len_done)
            begin
                if (len_masked)
                begin
                    kidx_next  = '0;
                    phase_next = PH_KEY;
                end
                else
                begin
                    hdr_done = 1'b1;
                    hdr_rem  = len_rem;
                end
            end

            if (hdr_done)
            begin
                kidx_next = '0;
                if (hdr_rem != '0)
                begin
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    phase_next = PH_HDR0;
                    if (emits)
                    begin
                        res_valid         = 1'b1;
                        res.frame_kind    = (op_reg == OP_PING);
                        res.empty_frame   = 1'b1;
                        res.last_in_frame = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            fin_reg     <= 1'b0;
            op_reg      <= '0;
            masked_reg  <= 1'b0;
            ext_cnt_reg <= '0;
            rem_reg     <= '0;
            key_reg     <= '0;
            kidx_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            fin_reg     <= fin_next;
            op_reg      <= op_next;
            masked_reg  <= masked_next;
            ext_cnt_reg <= ext_cnt_next;
            rem_reg     <= rem_next;
            key_reg     <= key_next;
            kidx_reg    <= kidx_next;
        end
    end

    `WSFD_ASSERT(a_key_needs_mask, clk, rst_n, (phase_reg == PH_KEY) |-> masked_reg, "key phase in unmasked frame")
    `WSFD_ASSERT_NEVER(a_payload_nonzero, clk, rst_n, (phase_reg == PH_PAYLOAD) && (rem_reg == '0), "payload phase with zero length left")
    `WSFD_ASSERT(a_result_emits, clk, rst_n, res_valid |-> emits, "result from silent frame")
    `WSFD_ASSERT(a_empty_is_last, clk, rst_n, (res_valid && res.empty_frame) |-> res.last_in_frame, "empty marker not last")
    `WSFD_ASSERT(a_last_restarts, clk, rst_n, (res_valid && res.last_in_frame) |=> (phase_reg == PH_HDR0), "frame end without header restart")

endmodule

### rtl/wsfd_out_stage.sv
// ----------------------------------------------------------------------------
// WebSocket frame decoder output stage
// Result register; frees itself in the same cycle its word is taken.
// ----------------------------------------------------------------------------
module wsfd_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    input  wsfd_pkg::res_t res,
    output logic           free,
    output logic           out_valid,
    input  logic           out_stall,
    output wsfd_pkg::res_t out_res
);
    import wsfd_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for websocket_frame_decoder
// Streams WebSocket frames into the decoder one word at a time, with random
// gaps on the input and random stall on the output. A directed table covers
// empty markers, silent frames, masking and a 64-bit length with its top bit
// set. Random frames of every opcode follow. Each output word is checked
// field by field against an in-bench frame parser.
// ----------------------------------------------------------------------------
module tb_top;

    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        P_HEAD0,
        P_HEAD1,
        P_EXTLEN,
        P_KEY,
        P_BODY
    } parse_ph_t;

    // one directed row: input word, plus a hand-typed result where obvious
    typedef struct packed {
        logic       typed;
        logic [7:0] b;
        res_t       want;
    } stim_row_t;

    localparam res_t NO_RES   = '0;
    localparam int   DIR_LEN  = 26;
    localparam int   TAIL_AT  = 14;
    localparam int   N_ITEMS  = 1450;

    // head: empty text, empty ping without fin, empty close, masked ping with
    // RSV bits set; tail: 64-bit length with the top bit set, never finishes
    stim_row_t dir_tab [DIR_LEN] = '{
        '{1'b0, 8'h81, NO_RES},
        '{1'b1, 8'h00, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{1'b0, 8'h09, NO_RES},
        '{1'b1, 8'h00, '{8'h00, 1'b1, 1'b1, 1'b1}},
        '{1'b0, 8'h88, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'hf9, NO_RES},
        '{1'b0, 8'h82, NO_RES},
        '{1'b0, 8'hff, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'haa, NO_RES},
        '{1'b0, 8'h55, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'hff, NO_RES},
        '{1'b0, 8'h81, NO_RES},
        '{1'b0, 8'h7f, NO_RES},
        '{1'b0, 8'h80, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b0, 8'h00, NO_RES},
        '{1'b1, 8'hff, '{8'hff, 1'b0, 1'b0, 1'b0}},
        '{1'b1, 8'h00, '{8'h00, 1'b0, 1'b0, 1'b0}}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] payload_byte;
    logic       frame_kind;
    logic       empty_frame;
    logic       last_in_frame;

    // parser copy
    parse_ph_t   ph;
    logic        fin_bit;
    logic [3:0]  opc;
    logic        masked;
    logic [2:0]  ext_left;
    logic [63:0] remain;
    logic [31:0] key;
    logic [1:0]  kidx;

    res_t        pending_res [$];
    logic        cur_typed;
    res_t        cur_want;
    logic        calm;
    int unsigned n_err;
    int unsigned n_in;
    int unsigned n_res;
    int unsigned n_empty;
    int unsigned n_frames;

    websocket_frame_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .frame_kind    (frame_kind),
        .empty_frame   (empty_frame),
        .last_in_frame (last_in_frame)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic frame_emits();
        return (opc == OP_TEXT && fin_bit) || opc == OP_PING;
    endfunction

    task automatic header_known(output logic got, output res_t r);
        got = 1'b0;
        r = NO_RES;
        kidx = 2'd0;
        if (remain != 64'd0)
        begin
            ph = P_BODY;
        end
        else
        begin
            ph = P_HEAD0;
            if (frame_emits())
            begin
                got = 1'b1;
                r.payload_byte  = 8'h00;
                r.frame_kind    = (opc == OP_PING);
                r.empty_frame   = 1'b1;
                r.last_in_frame = 1'b1;
            end
        end
    endtask

    task automatic length_known(output logic got, output res_t r);
        got = 1'b0;
        r = NO_RES;
        if (masked)
        begin
            kidx = 2'd0;
            ph = P_KEY;
        end
        else
        begin
            header_known(got, r);
        end
    endtask

    task automatic predict_word(input logic [7:0] b, output logic got, output res_t r);
        logic [7:0] kb;
        got = 1'b0;
        r = NO_RES;
        case (ph)
            P_HEAD0:
            begin
                fin_bit = b[7];
                opc = b[3:0];
                ph = P_HEAD1;
            end
            P_HEAD1:
            begin
                masked = b[7];
                key = 32'd0;
                remain = 64'd0;
                if (b[6:0] == LEN_CODE_16)
                begin
                    ext_left = EXT_CNT_16;
                    ph = P_EXTLEN;
                end
                else if (b[6:0] == LEN_CODE_64)
                begin
                    ext_left = EXT_CNT_64;
                    ph = P_EXTLEN;
                end
                else
                begin
                    ext_left = 3'd0;
                    remain = {57'd0, b[6:0]};
                    length_known(got, r);
                end
            end
            P_EXTLEN:
            begin
                remain = {remain[55:0], b};
                if (ext_left == 3'd0)
                    length_known(got, r);
                else
                    ext_left = ext_left - 3'd1;
            end
            P_KEY:
            begin
                key = {key[23:0], b};
                if (kidx == 2'd3)
                    header_known(got, r);
                else
                    kidx = kidx + 2'd1;
            end
            P_BODY:
            begin
                kb = key[(3 - kidx) * 8 +: 8];
                kidx = kidx + 2'd1;
                remain = remain - 64'd1;
                if (remain == 64'd0)
                    ph = P_HEAD0;
                if (frame_emits())
                begin
                    got = 1'b1;
                    r.payload_byte  = b ^ kb;
                    r.frame_kind    = (opc == OP_PING);
                    r.empty_frame   = 1'b0;
                    r.last_in_frame = (remain == 64'd0);
                end
            end
            default:
                ph = P_HEAD0;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (a !== e)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
            n_err++;
        end
    endtask

    // input words feed the parser, output words are checked against it
    always @(posedge clk)
    begin : watch
        logic got;
        res_t r;
        if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0)
        begin
            predict_word(rx_byte, got, r);
            n_in++;
            if (cur_typed)
                pending_res.push_back(cur_want);
            else if (got)
                pending_res.push_back(r);
        end
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_res.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got %0h/%0b/%0b/%0b", $time,
                         payload_byte, frame_kind, empty_frame, last_in_frame);
                n_err++;
            end
            else
            begin
                r = pending_res.pop_front();
                check_field("payload_byte", r.payload_byte, payload_byte);
                check_field("frame_kind", {7'd0, r.frame_kind}, {7'd0, frame_kind});
                check_field("empty_frame", {7'd0, r.empty_frame}, {7'd0, empty_frame});
                check_field("last_in_frame", {7'd0, r.last_in_frame}, {7'd0, last_in_frame});
                n_res++;
                if (r.empty_frame)
                    n_empty++;
            end
        end
    end

    // mostly none, some short, a few long; nothing during calm stretches
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial
    begin
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(100, 400)) @(negedge clk);
            calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin : rx_side
        int unsigned n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = pick_gap();
            @(negedge clk);
            out_stall = (n != 0);
            if (n > 1)
                repeat (n - 1) @(negedge clk);
        end
    end

    // entered and left at a falling edge
    task automatic send_word(input logic [7:0] b, input logic typed = 1'b0,
                             input res_t want = NO_RES);
        int unsigned n;
        n = pick_gap();
        if (n != 0)
        begin
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte = b;
        cur_typed = typed;
        cur_want = want;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_res.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_frame();
        logic [7:0]  h0;
        logic [3:0]  op;
        logic        fin;
        logic        msk;
        logic [31:0] k;
        logic [63:0] len64;
        int unsigned sel;
        int unsigned len;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            op = OP_TEXT;
        else if (sel < 65)
            op = OP_PING;
        else
            op = 4'($urandom_range(0, 15));
        fin = ($urandom_range(0, 9) != 0);
        h0 = {fin, 3'($urandom_range(0, 7)), op};
        if ($urandom_range(0, 9) == 0)
            h0 = 8'($urandom_range(0, 255));
        msk = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (sel < 12)
            len = 0;
        else if (sel < 75)
            len = $urandom_range(1, 12);
        else if (sel < 88)
            len = $urandom_range(13, 125);
        else if (sel < 96)
            len = $urandom_range(0, 300);
        else
            len = $urandom_range(0, 40);
        len64 = 64'(len);
        send_word(h0);
        if (sel < 88)
        begin
            send_word({msk, 7'(len)});
        end
        else if (sel < 96)
        begin
            send_word({msk, LEN_CODE_16});
            send_word(len64[15:8]);
            send_word(len64[7:0]);
        end
        else
        begin
            send_word({msk, LEN_CODE_64});
            for (int i = 7; i >= 0; i--)
                send_word(len64[i * 8 +: 8]);
        end
        if (msk)
        begin
            k = $urandom;
            for (int i = 3; i >= 0; i--)
                send_word(k[i * 8 +: 8]);
        end
        for (int i = 0; i < int'(len); i++)
            send_word(8'($urandom_range(0, 255)));
        n_frames++;
    endtask

    initial
    begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        cur_typed = 1'b0;
        cur_want = NO_RES;
        n_err = 0;
        n_in = 0;
        n_res = 0;
        n_empty = 0;
        n_frames = 0;
        ph = P_HEAD0;
        fin_bit = 1'b0;
        opc = 4'd0;
        masked = 1'b0;
        ext_left = 3'd0;
        remain = 64'd0;
        key = 32'd0;
        kidx = 2'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < TAIL_AT; i++)
            send_word(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
        wait_drained();

        // leave room for the tail rows in the word budget
        while (n_in < N_ITEMS - (DIR_LEN - TAIL_AT))
        begin
            if ($urandom_range(0, 29) == 0)
                wait_drained();
            send_frame();
        end

        // last: a length that never runs out, so the decoder stays in payload
        for (int i = TAIL_AT; i < DIR_LEN; i++)
            send_word(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
        wait_drained();
        repeat (20) @(negedge clk);

        $display("tb_top: %0d words in, %0d random frames, %0d results checked",
                 n_in, n_frames, n_res);
        $display("tb_top: %0d empty markers, %0d mismatches", n_empty, n_err);
        if (n_err == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
